FILE: rtl/tic_pkg.sv
// shared types and constants for the tournament isomorphism checker
package tic_pkg;
  localparam int MaxV = 8;
  localparam int RowW = 8;
  localparam int DegW = 4;
  localparam int IdxW = 3;
  localparam int AdjW = 64;

  // operation codes of an input beat
  localparam logic OpPair         = 1'b0;
  localparam logic OpSelfConverse = 1'b1;

  typedef logic [RowW-1:0] row_t;
  typedef logic [DegW-1:0] deg_t;
  typedef logic [IdxW-1:0] idx_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;
    logic hist;
    logic sort_step;
    logic try_cand;
    logic push;
    logic pop;
  } tic_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic compat;
    logic run_search;
    logic sort_done;
    logic cand_ok;
    logic cand_end;
    logic depth_full;
    logic depth_zero;
  } tic_sts_t;

  function automatic deg_t popc(input row_t x);
    deg_t c;
    c = '0;
    for (int i = 0; i < RowW; i++) c = c + deg_t'(x[i]);
    return c;
  endfunction
endpackage

FILE: rtl/tic_if.sv
// valid/ready channel interfaces for input and result beats
interface tic_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] first_adjacency;
  logic [63:0] second_adjacency;
  modport source (output valid, op, first_adjacency, second_adjacency, input ready);
  modport sink   (input valid, op, first_adjacency, second_adjacency, output ready);
endinterface

interface tic_out_if;
  logic valid;
  logic ready;
  logic match;
  logic scores_compatible;
  modport source (output valid, match, scores_compatible, input ready);
  modport sink   (input valid, match, scores_compatible, output ready);
endinterface

FILE: rtl/tic_datapath.sv
// datapath: rows, degrees, histograms, vertex ordering and backtracking stack
module tic_datapath #(
  parameter int VERTICES = 8
) (
  input  logic                  clk,
  input  logic                  op,
  input  logic [63:0]           first_adjacency,
  input  logic [63:0]           second_adjacency,
  input  tic_pkg::tic_cmd_t     cmd,
  output tic_pkg::tic_sts_t     sts
);
  import tic_pkg::*;

  localparam int NBins = VERTICES + 1;
  localparam row_t VMask = row_t'((1 << VERTICES) - 1);

  row_t a_row_r [VERTICES];
  row_t b_row_r [VERTICES];
  deg_t a_deg_r [VERTICES];
  deg_t b_deg_r [VERTICES];
  deg_t rar_r   [NBins];
  logic compat_r, run_r;
  idx_t walk_r  [VERTICES];
  idx_t img_r   [VERTICES];
  idx_t cand_r  [VERTICES];
  logic [IdxW:0] pos_r;
  logic [IdxW:0] sort_i_r;
  logic [VERTICES-1:0] used_r;
  logic skip_r;

  // load rows and degrees
  row_t ra [VERTICES];
  row_t rb [VERTICES];
  always_comb begin
    for (int i = 0; i < VERTICES; i++) begin
      ra[i] = first_adjacency[8*i +: 8] & VMask;
      if (op == OpSelfConverse) rb[i] = ~ra[i] & (VMask ^ row_t'(1 << i));
      else                      rb[i] = second_adjacency[8*i +: 8] & VMask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < VERTICES; i++) begin
        a_row_r[i] <= ra[i];
        b_row_r[i] <= rb[i];
        a_deg_r[i] <= popc(ra[i]);
        b_deg_r[i] <= popc(rb[i]);
      end
    end
  end

  // histograms and compatibility
  deg_t ha [NBins];
  deg_t hb [NBins];
  logic heq, hsym;
  always_comb begin
    for (int d = 0; d < NBins; d++) begin
      ha[d] = '0;
      hb[d] = '0;
      for (int i = 0; i < VERTICES; i++) begin
        ha[d] = ha[d] + deg_t'(a_deg_r[i] == deg_t'(d));
        hb[d] = hb[d] + deg_t'(b_deg_r[i] == deg_t'(d));
      end
    end
    heq = 1'b1;
    for (int d = 0; d < NBins; d++) if (ha[d] != hb[d]) heq = 1'b0;
    hsym = 1'b1;
    for (int d = 0; d < VERTICES; d++) if (ha[d] != ha[VERTICES-1-d]) hsym = 1'b0;
  end

  logic op_r;
  always_ff @(posedge clk) begin
    if (cmd.load) op_r <= op;
    if (cmd.hist) begin
      for (int d = 0; d < NBins; d++) rar_r[d] <= ha[d];
      compat_r <= (op_r == OpSelfConverse) ? hsym : heq;
      run_r    <= (op_r == OpSelfConverse) ? (hsym && heq) : heq;
    end
  end

  // ordering: one vertex placed per step by rank counting
  function automatic logic bef(input int u, input int v);
    deg_t du, dv;
    du = a_deg_r[u];
    dv = a_deg_r[v];
    if (rar_r[du] != rar_r[dv]) return rar_r[du] < rar_r[dv];
    if (du != dv) return du < dv;
    return u < v;
  endfunction

  idx_t rank;
  idx_t si;
  always_comb begin
    si = sort_i_r[IdxW-1:0];
    rank = '0;
    for (int v = 0; v < VERTICES; v++)
      if (v != int'(si) && bef(v, int'(si))) rank = rank + idx_t'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.hist) sort_i_r <= '0;
    else if (cmd.sort_step) begin
      walk_r[rank] <= si;
      sort_i_r <= sort_i_r + 1'b1;
    end
  end

  // search: candidate test at current depth, blocked right after a backtrack
  idx_t pidx;
  idx_t u;
  idx_t v;
  logic ok;
  always_comb begin
    pidx = pos_r[IdxW-1:0];
    u = walk_r[pidx];
    v = cand_r[pidx];
    ok = !skip_r && !used_r[v] && (a_deg_r[u] == b_deg_r[v]);
    for (int k = 0; k < VERTICES; k++)
      if (k < int'(pos_r))
        if (a_row_r[u][walk_r[k]] != b_row_r[v][img_r[walk_r[k]]]) ok = 1'b0;
  end

  // after a backtrack the parent keeps its candidate and moves past it next step
  always_ff @(posedge clk) begin
    if (cmd.hist) begin
      pos_r  <= '0;
      used_r <= '0;
      cand_r[0] <= '0;
      skip_r <= 1'b0;
    end else if (cmd.push) begin
      img_r[u] <= v;
      used_r[v] <= 1'b1;
      pos_r <= pos_r + 1'b1;
      skip_r <= 1'b0;
      if (int'(pos_r) < VERTICES - 1) cand_r[pidx + idx_t'(1)] <= '0;
    end else if (cmd.pop) begin
      pos_r <= pos_r - 1'b1;
      used_r[img_r[walk_r[pidx - idx_t'(1)]]] <= 1'b0;
      skip_r <= 1'b1;
    end else if (cmd.try_cand) begin
      cand_r[pidx] <= v + idx_t'(1);
      skip_r <= 1'b0;
    end
  end

  assign sts.compat     = compat_r;
  assign sts.run_search = run_r;
  assign sts.sort_done  = (int'(sort_i_r) == VERTICES);
  assign sts.cand_ok    = ok;
  assign sts.cand_end   = (int'(v) >= VERTICES - 1);
  assign sts.depth_full = (int'(pos_r) == VERTICES);
  assign sts.depth_zero = (pos_r == '0);
endmodule

FILE: rtl/tic_ctrl.sv
// controller: sequences load, histogram, ordering and backtracking
module tic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_match,
  output logic              out_compat,
  output tic_pkg::tic_cmd_t cmd,
  input  tic_pkg::tic_sts_t sts
);
  import tic_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_HIST, S_CHK, S_SORT, S_SRCH, S_DONE} state_t;
  state_t state_r;
  logic   ovalid_r, match_r, compat_r;

  assign in_ready   = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid  = ovalid_r;
  assign out_match  = match_r;
  assign out_compat = compat_r;

  // command decode
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load = in_valid && in_ready;
      S_HIST: cmd.hist = 1'b1;
      S_SORT: cmd.sort_step = !sts.sort_done;
      S_SRCH: begin
        if (!sts.depth_full) begin
          if (sts.cand_ok) cmd.push = 1'b1;
          else if (!sts.cand_end) cmd.try_cand = 1'b1;
          else if (!sts.depth_zero) cmd.pop = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      match_r  <= 1'b0;
      compat_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) state_r <= S_HIST;
        S_HIST: state_r <= S_CHK;
        S_CHK: begin
          compat_r <= sts.compat;
          if (sts.run_search) state_r <= S_SORT;
          else begin
            match_r  <= 1'b0;
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_SORT: if (sts.sort_done) state_r <= S_SRCH;
        S_SRCH: begin
          if (sts.depth_full) begin
            match_r <= 1'b1;
            state_r <= S_DONE;
          end else if (!sts.cand_ok && sts.cand_end && sts.depth_zero) begin
            match_r <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/tournament_isomorphism_checker.sv
// tournament isomorphism checker: top level
// result: out valid is raised from the check state on histogram reject; else the
// ordering runs and then the search, which steps through candidate tries, descents and
// backtracks, stepping past the abandoned candidate after each backtrack
// throughput: one item at a time, next beat accepted the cycle after the result leaves
// reset: synchronous active-low rst_n clears controller state and output valid
module tournament_isomorphism_checker #(
  parameter int VERTICES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  tic_in_if.sink     in_ch,
  tic_out_if.source  out_ch
);
  import tic_pkg::*;

  tic_cmd_t cmd;
  tic_sts_t sts;

  tic_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_match  (out_ch.match),
    .out_compat (out_ch.scores_compatible),
    .cmd        (cmd),
    .sts        (sts)
  );

  tic_datapath #(.VERTICES(VERTICES)) u_dp (
    .clk              (clk),
    .op               (in_ch.op),
    .first_adjacency  (in_ch.first_adjacency),
    .second_adjacency (in_ch.second_adjacency),
    .cmd              (cmd),
    .sts              (sts)
  );
endmodule

FILE: tb/tb_tournament_isomorphism_checker.sv
// testbench for the tournament isomorphism checker with its own search predictor
module tb_tournament_isomorphism_checker;
  import tic_pkg::*;

  localparam int NV = 8;

  typedef struct packed {
    logic match;
    logic scores_compatible;
  } verdict_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  verdict_t verdicts_due[$];

  tic_in_if  in_ch ();
  tic_out_if out_ch ();

  tournament_isomorphism_checker #(.VERTICES(NV)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // outer time limit
  initial begin
    #200000000;
    $display("Some tests failed");
    $finish;
  end

  // row and degree unpacking
  function automatic row_t row_of(input logic [63:0] adj, input int i);
    return adj[8*i +: 8];
  endfunction

  function automatic int ones(input row_t r);
    int c;
    c = 0;
    for (int i = 0; i < NV; i++) c += r[i];
    return c;
  endfunction

  // depth-first mapping search, ordered by histogram rarity, degree, index
  function automatic logic maps_onto(input row_t ar [NV], input row_t br [NV],
                                     output logic hist_same);
    int ad [NV];
    int bd [NV];
    int ha [9];
    int hb [9];
    int order [NV];
    int image [NV];
    int next_cand [NV];
    int depth;
    int t;
    int j;
    int u;
    int v;
    logic [NV-1:0] taken;
    logic found;
    logic ok;
    for (int i = 0; i < 9; i++) begin
      ha[i] = 0;
      hb[i] = 0;
    end
    for (int i = 0; i < NV; i++) begin
      ad[i] = ones(ar[i]);
      bd[i] = ones(br[i]);
      ha[ad[i]]++;
      hb[bd[i]]++;
    end
    hist_same = 1'b1;
    for (int i = 0; i < 9; i++) if (ha[i] != hb[i]) hist_same = 1'b0;
    if (!hist_same) return 1'b0;
    // insertion sort of the visiting order
    for (int i = 0; i < NV; i++) begin
      t = i;
      j = i;
      while (j > 0) begin
        u = order[j-1];
        if (ha[ad[t]] != ha[ad[u]]) ok = ha[ad[t]] < ha[ad[u]];
        else if (ad[t] != ad[u]) ok = ad[t] < ad[u];
        else ok = t < u;
        if (!ok) break;
        order[j] = order[j-1];
        j--;
      end
      order[j] = t;
    end
    for (int i = 0; i < NV; i++) image[i] = 0;
    depth = 0;
    taken = '0;
    next_cand[0] = 0;
    // only arcs from the new vertex to earlier mapped ones are compared
    while (depth < NV) begin
      u = order[depth];
      found = 1'b0;
      for (v = next_cand[depth]; v < NV && !found; v++) begin
        if (!taken[v] && ad[u] == bd[v]) begin
          ok = 1'b1;
          for (int k = 0; k < depth; k++)
            if (ar[u][order[k]] != br[v][image[order[k]]]) ok = 1'b0;
          if (ok) begin
            found = 1'b1;
            image[u] = v;
            next_cand[depth] = v + 1;
          end
        end
      end
      if (found) begin
        taken[image[u]] = 1'b1;
        depth++;
        if (depth < NV) next_cand[depth] = 0;
      end else begin
        if (depth == 0) return 1'b0;
        depth--;
        taken[image[order[depth]]] = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic verdict_t expected_verdict(input logic op, input logic [63:0] fa,
                                                input logic [63:0] sa);
    row_t ar [NV];
    row_t br [NV];
    int h [9];
    logic same;
    verdict_t r;
    for (int i = 0; i < 9; i++) h[i] = 0;
    for (int i = 0; i < NV; i++) begin
      ar[i] = row_of(fa, i);
      br[i] = row_of(sa, i);
      h[ones(ar[i])]++;
    end
    if (op == OpPair) begin
      r.match = maps_onto(ar, br, same);
      r.scores_compatible = same;
    end else begin
      r.scores_compatible = 1'b1;
      for (int i = 0; i < NV; i++) if (h[i] != h[NV-1-i]) r.scores_compatible = 1'b0;
      r.match = 1'b0;
      if (r.scores_compatible) begin
        for (int i = 0; i < NV; i++) br[i] = ~ar[i] & ~(row_t'(1) << i);
        r.match = maps_onto(ar, br, same);
      end
    end
    return r;
  endfunction

  // random tournament and relabeling helpers
  function automatic logic [63:0] random_tournament();
    logic [63:0] a;
    a = '0;
    for (int i = 0; i < NV; i++)
      for (int j = i + 1; j < NV; j++)
        if ($urandom_range(1)) a[8*i+j] = 1'b1;
        else a[8*j+i] = 1'b1;
    return a;
  endfunction

  function automatic logic [63:0] relabel(input logic [63:0] a);
    int p [NV];
    int k;
    int t;
    logic [63:0] b;
    for (int i = 0; i < NV; i++) p[i] = i;
    for (int i = NV - 1; i > 0; i--) begin
      k = $urandom_range(i);
      t = p[i];
      p[i] = p[k];
      p[k] = t;
    end
    b = '0;
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++)
        b[8*p[i]+p[j]] = a[8*i+j];
    return b;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // mismatch report
  task automatic report(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  // send one beat and record its expected verdict
  task automatic send_beat(input logic op, input logic [63:0] fa, input logic [63:0] sa);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.first_adjacency = fa;
    in_ch.second_adjacency = sa;
    do @(posedge clk); while (!in_ch.ready);
    verdicts_due = {verdicts_due, expected_verdict(op, fa, sa)};
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result check
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = verdicts_due.pop_front();
        if (out_ch.match !== e.match)
          report($sformatf("match got %b want %b", out_ch.match, e.match));
        if (out_ch.scores_compatible !== e.scores_compatible)
          report($sformatf("scores_compatible got %b want %b",
                           out_ch.scores_compatible, e.scores_compatible));
      end
    end
  end

  // corner items: empty, full, transitive, circulant, self loops
  task automatic test_directed();
    logic [63:0] trans;
    logic [63:0] circ;
    trans = '0;
    circ = '0;
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++) begin
        if (i < j) trans[8*i+j] = 1'b1;
        if (((j - i + NV) % NV) inside {1, 2, 3} || (j - i == 4)) circ[8*i+j] = 1'b1;
      end
    send_beat(OpPair, '0, '0);
    send_beat(OpPair, '1, '1);
    send_beat(OpPair, '0, '1);
    send_beat(OpSelfConverse, '0, '1);
    send_beat(OpSelfConverse, '1, '0);
    send_beat(OpPair, trans, relabel(trans));
    send_beat(OpSelfConverse, trans, '0);
    send_beat(OpSelfConverse, circ, '1);
    send_beat(OpPair, circ, relabel(circ));
    send_beat(OpPair, circ, trans);
    send_beat(OpPair, trans | 64'h8040201008040201, trans);
    send_beat(OpSelfConverse, trans | 64'h8040201008040201, '0);
    send_beat(OpPair, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_beat(OpSelfConverse, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
  endtask

  // relabeled copies, sometimes with one arc flipped
  task automatic test_isomorphic_pairs(input int n);
    logic [63:0] a;
    logic [63:0] b;
    int i;
    int j;
    repeat (n) begin
      a = random_tournament();
      b = relabel(a);
      if ($urandom_range(3) == 0) begin
        i = $urandom_range(NV - 1);
        j = (i + 1 + $urandom_range(NV - 2)) % NV;
        b[8*i+j] = ~b[8*i+j];
        b[8*j+i] = ~b[8*j+i];
      end
      send_beat(OpPair, a, b);
    end
  endtask

  // self-converse test on random tournaments with a junk second word
  task automatic test_self_converse(input int n);
    logic [63:0] a;
    repeat (n) begin
      a = random_tournament();
      send_beat(OpSelfConverse, a, random_word());
    end
  endtask

  // arbitrary bit patterns on both ops
  task automatic test_noise(input int n);
    repeat (n) send_beat(logic'($urandom_range(1)), random_word(), random_word());
  endtask

  task automatic drain();
    go_quiet();
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 9;
    recv_idle_pct = 63;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OpPair;
    in_ch.first_adjacency = '0;
    in_ch.second_adjacency = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_isomorphic_pairs(250);
    drain();
    test_self_converse(200);
    send_idle_pct = 63;
    recv_idle_pct = 9;
    test_noise(200);
    test_isomorphic_pairs(250);
    test_self_converse(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_noise(200);
    test_isomorphic_pairs(250);
    test_self_converse(250);
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/tic_pkg.sv
rtl/tic_if.sv
rtl/tic_datapath.sv
rtl/tic_ctrl.sv
rtl/tournament_isomorphism_checker.sv
tb/tb_tournament_isomorphism_checker.sv
